FILE: rtl/dq_pkg.sv
// Shared types for the double-ended queue core: operation codes, result
// status codes and controller states. No dependencies.
`default_nettype none

package dq_pkg;

  // Operation carried by each request item
  typedef enum logic [1:0] {
    OP_PUSH_BACK  = 2'd0,
    OP_POP_BACK   = 2'd1,
    OP_PUSH_FRONT = 2'd2,
    OP_POP_FRONT  = 2'd3
  } op_t;

  // Outcome reported with each response item
  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } status_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_READ = 2'd1,
    S_LOAD = 2'd2
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/dq_req_if.sv
// Request channel of the double-ended queue: valid/ready plus opcode and value.
// Depends on dq_pkg.
`default_nettype none

interface dq_req_if #(
  parameter int DATA_WIDTH = 32
);
  logic                  valid;
  logic                  ready;
  dq_pkg::op_t           opcode;
  logic [DATA_WIDTH-1:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

`default_nettype wire

FILE: rtl/dq_rsp_if.sv
// Response channel of the double-ended queue: valid/ready plus status, count
// and the front and back elements. Depends on dq_pkg.
`default_nettype none

interface dq_rsp_if #(
  parameter int DATA_WIDTH = 32,
  parameter int CNT_W      = 5
);
  logic                  valid;
  logic                  ready;
  dq_pkg::status_t       status;
  logic [CNT_W-1:0]      count;
  logic [DATA_WIDTH-1:0] front_value;
  logic [DATA_WIDTH-1:0] back_value;

  modport source (output valid, output status, output count, output front_value,
                  output back_value, input ready);
  modport sink   (input valid, input status, input count, input front_value,
                  input back_value, output ready);
endinterface

`default_nettype wire

FILE: rtl/dq_ram.sv
// Generic synchronous RAM: one write port, two read ports sharing one enable,
// registered read data. No dependencies.
`default_nettype none

module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read ports, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/double_ended_queue_core.sv
// Bounded double-ended queue of DEPTH elements kept as a ring in a RAM with
// one write and two read ports. Each request item is one of push back, pop
// back, push front or pop front, and yields exactly one response item with
// the status, the count after the operation and the front and back elements
// (zero when the queue is empty). A pop on an empty queue or a push on a full
// one leaves the queue unchanged and is flagged in the status. Each item
// passes through S_IDLE, whose accept cycle updates head and count and
// writes the RAM, S_READ in the cycle after, which reads front and back
// on the two RAM read ports, and S_LOAD, which loads the response register;
// the next item is taken back in S_IDLE. A new item is accepted while an
// earlier response still waits; S_LOAD waits only while the response register
// is occupied and stalled. Depends on dq_pkg, dq_req_if, dq_rsp_if and dq_ram.
`default_nettype none

module double_ended_queue_core #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input wire logic clk,
  input wire logic rst,
  dq_req_if.sink   req,
  dq_rsp_if.source rsp
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int SW = CNT_W + 1;
  localparam logic [SW-1:0]    DEPTH_S = SW'(DEPTH);
  localparam logic [CNT_W-1:0] FULL_C  = CNT_W'(DEPTH);
  localparam logic [AW-1:0]    LAST_A  = AW'(DEPTH - 1);

  dq_pkg::state_t  state, state_next;
  logic [AW-1:0]   head, head_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  dq_pkg::status_t st, st_next;

  logic                  req_ready, accept, rd_en, load;
  logic                  full, empty;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr, head_inc, head_dec, tail_addr, back_addr;
  logic [SW-1:0]         tail_sum, back_sum;
  logic [DATA_WIDTH-1:0] rd_front, rd_back;

  logic                  out_valid;
  dq_pkg::status_t       out_status;
  logic [CNT_W-1:0]      out_count;
  logic [DATA_WIDTH-1:0] out_front, out_back;

  // controller state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and strobes
  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    rd_en      = 1'b0;
    load       = 1'b0;
    unique case (state)
      dq_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req.valid) state_next = dq_pkg::S_READ;
      end
      dq_pkg::S_READ: begin
        rd_en      = 1'b1;
        state_next = dq_pkg::S_LOAD;
      end
      dq_pkg::S_LOAD: begin
        if (!out_valid || rsp.ready) begin
          load       = 1'b1;
          state_next = dq_pkg::S_IDLE;
        end
      end
      default: state_next = dq_pkg::S_IDLE;
    endcase
  end

  assign req.ready = req_ready;
  assign accept    = req_ready && req.valid;

  // ring arithmetic on the head index
  assign full     = (cnt == FULL_C);
  assign empty    = (cnt == '0);
  assign head_inc = (head == LAST_A) ? '0 : head + AW'(1);
  assign head_dec = (head == '0) ? LAST_A : head - AW'(1);
  assign tail_sum = SW'(head) + SW'(cnt);
  assign tail_addr = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);
  assign back_sum = SW'(head) + SW'(cnt) - SW'(1);
  always_comb begin
    if (empty) begin
      back_addr = head;
    end else if (back_sum >= DEPTH_S) begin
      back_addr = AW'(back_sum - DEPTH_S);
    end else begin
      back_addr = AW'(back_sum);
    end
  end

  // operation decode
  always_comb begin
    head_next = head;
    cnt_next  = cnt;
    st_next   = dq_pkg::ST_DONE;
    wr_en     = 1'b0;
    wr_addr   = tail_addr;
    case (req.opcode)
      dq_pkg::OP_PUSH_BACK: begin
        if (full) begin
          st_next = dq_pkg::ST_PUSH_FULL;
        end else begin
          wr_en    = 1'b1;
          cnt_next = cnt + CNT_W'(1);
        end
      end
      dq_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          st_next = dq_pkg::ST_PUSH_FULL;
        end else begin
          wr_en     = 1'b1;
          wr_addr   = head_dec;
          head_next = head_dec;
          cnt_next  = cnt + CNT_W'(1);
        end
      end
      dq_pkg::OP_POP_BACK: begin
        if (empty) begin
          st_next = dq_pkg::ST_POP_EMPTY;
        end else begin
          cnt_next = cnt - CNT_W'(1);
        end
      end
      dq_pkg::OP_POP_FRONT: begin
        if (empty) begin
          st_next = dq_pkg::ST_POP_EMPTY;
        end else begin
          head_next = head_inc;
          cnt_next  = cnt - CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // queue pointers and latched status
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      cnt  <= '0;
      st   <= dq_pkg::ST_DONE;
    end else if (accept) begin
      head <= head_next;
      cnt  <= cnt_next;
      st   <= st_next;
    end
  end

  // element store; reads come in the cycle after the write, so no forwarding
  dq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (accept && wr_en),
    .waddr   (wr_addr),
    .wdata   (req.value),
    .re      (rd_en),
    .raddr_a (head),
    .raddr_b (back_addr),
    .rdata_a (rd_front),
    .rdata_b (rd_back)
  );

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status <= st;
      out_count  <= cnt;
      out_front  <= empty ? '0 : rd_front;
      out_back   <= empty ? '0 : rd_back;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.count       = out_count;
  assign rsp.front_value = out_front;
  assign rsp.back_value  = out_back;

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= FULL_C)
    else $error("element count above depth");

  a_accept_read: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == dq_pkg::S_READ))
    else $error("accepted item not followed by a read cycle");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    (accept && !full && (req.opcode == dq_pkg::OP_PUSH_BACK ||
                         req.opcode == dq_pkg::OP_PUSH_FRONT))
    |=> (cnt == $past(cnt) + CNT_W'(1)))
    else $error("push did not grow the queue");

  a_flag_unchanged: assert property (@(posedge clk) disable iff (rst)
    (accept && st_next != dq_pkg::ST_DONE) |=> ($stable(cnt) && $stable(head)))
    else $error("flagged operation changed the queue");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.count == '0) |-> (rsp.front_value == '0 && rsp.back_value == '0))
    else $error("empty queue reported non-zero elements");

endmodule

`default_nettype wire
